@@ design/mbnpc_pkg.sv @@
// ----------------------------------------------------------------------------
// mbnpc_pkg
// Shared types and opcode constants for the branch resume-address block.
// ----------------------------------------------------------------------------
package mbnpc_pkg;

  localparam int unsigned InDataW  = 224;
  localparam int unsigned OutDataW = 136;

  localparam logic [5:0] OpcSpecial = 6'h00;
  localparam logic [5:0] OpcRegimm  = 6'h01;
  localparam logic [5:0] OpcJ       = 6'h02;
  localparam logic [5:0] OpcJal     = 6'h03;
  localparam logic [5:0] OpcBeq     = 6'h04;
  localparam logic [5:0] OpcBne     = 6'h05;
  localparam logic [5:0] OpcBlez    = 6'h06;
  localparam logic [5:0] OpcBgtz    = 6'h07;
  localparam logic [5:0] OpcBeql    = 6'h14;
  localparam logic [5:0] OpcBnel    = 6'h15;
  localparam logic [5:0] OpcBlezl   = 6'h16;
  localparam logic [5:0] OpcBgtzl   = 6'h17;

  localparam logic [5:0] FunJr      = 6'h08;
  localparam logic [5:0] FunJalr    = 6'h09;

  localparam logic [4:0] RtBltz     = 5'h00;
  localparam logic [4:0] RtBgez     = 5'h01;
  localparam logic [4:0] RtBltzl    = 5'h02;
  localparam logic [4:0] RtBgezl    = 5'h03;
  localparam logic [4:0] RtBltzal   = 5'h10;
  localparam logic [4:0] RtBgezal   = 5'h11;
  localparam logic [4:0] RtBltzall  = 5'h12;
  localparam logic [4:0] RtBgezall  = 5'h13;

  localparam logic [4:0] RaIndex    = 5'd31;

  typedef struct packed {
    logic [63:0]        pc;
    logic               in_delay_slot;
    logic [31:0]        instruction;
    logic signed [63:0] rs_value;
    logic signed [63:0] rt_value;
  } req_t;

  typedef struct packed {
    logic [63:0] next_pc;
    logic        link_write;
    logic [4:0]  link_reg;
    logic [63:0] link_value;
    logic        not_branch;
  } res_t;

endpackage

@@ design/mbnpc_decode.sv @@
// ----------------------------------------------------------------------------
// mbnpc_decode
// Decodes the branch or jump at the exception pc and forms the resume address
// and link information.
// ----------------------------------------------------------------------------
module mbnpc_decode (
  input  mbnpc_pkg::req_t req,
  output mbnpc_pkg::res_t res
);
  import mbnpc_pkg::*;

  logic [5:0]  op;
  logic [4:0]  rt_f;
  logic [4:0]  rd_f;
  logic [5:0]  fn;
  logic [63:0] pc4;
  logic [63:0] pc8;
  logic [63:0] btarget;
  logic [63:0] jtarget;
  logic        neg;
  logic        zero;
  logic        eq;

  assign op      = req.instruction[31:26];
  assign rt_f    = req.instruction[20:16];
  assign rd_f    = req.instruction[15:11];
  assign fn      = req.instruction[5:0];
  assign pc4     = req.pc + 64'd4;
  assign pc8     = req.pc + 64'd8;
  assign btarget = req.pc + {{46{req.instruction[15]}}, req.instruction[15:0], 2'b00}
                   + 64'd4;
  assign jtarget = {pc4[63:28], req.instruction[25:0], 2'b00};
  assign neg     = req.rs_value[63];
  assign zero    = (req.rs_value == 64'sd0);
  assign eq      = (req.rs_value == req.rt_value);

  always_comb begin
    logic valid;
    logic link;
    logic [63:0] nxt;
    logic [4:0]  lreg;
    valid = 1'b1;
    link  = 1'b0;
    lreg  = RaIndex;
    nxt   = pc8;
    unique case (op)
      OpcSpecial: begin
        if (fn == FunJr || fn == FunJalr) begin
          nxt = req.rs_value;
          if (fn == FunJalr) begin
            link = 1'b1;
            lreg = rd_f;
          end
        end else begin
          valid = 1'b0;
        end
      end
      OpcJ: nxt = jtarget;
      OpcJal: begin
        nxt  = jtarget;
        link = 1'b1;
      end
      OpcRegimm: begin
        unique case (rt_f)
          RtBltz, RtBltzl: nxt = neg ? btarget : pc8;
          RtBgez, RtBgezl: nxt = neg ? pc8 : btarget;
          RtBltzal, RtBltzall: begin
            nxt  = neg ? btarget : pc8;
            link = 1'b1;
          end
          RtBgezal, RtBgezall: begin
            nxt  = neg ? pc8 : btarget;
            link = 1'b1;
          end
          default: valid = 1'b0;
        endcase
      end
      OpcBlez, OpcBlezl: nxt = (neg || zero) ? btarget : pc8;
      OpcBgtz, OpcBgtzl: nxt = (!neg && !zero) ? btarget : pc8;
      OpcBeq, OpcBeql:   nxt = eq ? btarget : pc8;
      OpcBne, OpcBnel:   nxt = eq ? pc8 : btarget;
      default: valid = 1'b0;
    endcase

    if (!req.in_delay_slot) begin
      res.next_pc    = pc4;
      res.link_write = 1'b0;
      res.link_reg   = 5'd0;
      res.link_value = 64'd0;
      res.not_branch = 1'b0;
    end else if (!valid) begin
      res.next_pc    = pc8;
      res.link_write = 1'b0;
      res.link_reg   = 5'd0;
      res.link_value = 64'd0;
      res.not_branch = 1'b1;
    end else begin
      res.next_pc    = nxt;
      res.link_write = link;
      res.link_reg   = link ? lreg : 5'd0;
      res.link_value = link ? pc8 : 64'd0;
      res.not_branch = 1'b0;
    end
  end

endmodule

@@ design/mips_branch_next_pc.sv @@
// ----------------------------------------------------------------------------
// mips_branch_next_pc
// Resume address after an exception: pc + 4, or the outcome of the branch or
// jump whose delay slot held the victim, with link register and value.
// ----------------------------------------------------------------------------
// One request per cycle while the result side keeps taking results: a request is
// captured in an input register, decoded and compared in one pass, and held
// in a result register until taken. Backpressure from the result side stalls
// each stage only when it is full.
module mips_branch_next_pc (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // pc[63:0], instruction[95:64], rs_value[159:96], rt_value[223:160]
  input  logic [mbnpc_pkg::InDataW-1:0]   in_tdata,
  // in_delay_slot[0]
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // next_pc[63:0], link_write[64], link_reg[69:65], link_value[133:70], zero pad
  output logic [mbnpc_pkg::OutDataW-1:0]  out_tdata,
  // not_branch[0]
  output logic                            out_tuser
);
  import mbnpc_pkg::*;

  logic in_valid_r;
  req_t req_r;
  logic out_valid_r;
  res_t res_r;
  res_t res_nxt;
  logic out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      req_r.pc            <= in_tdata[63:0];
      req_r.in_delay_slot <= in_tuser;
      req_r.instruction   <= in_tdata[95:64];
      req_r.rs_value      <= in_tdata[159:96];
      req_r.rt_value      <= in_tdata[223:160];
    end
  end

  mbnpc_decode u_decode (
    .req (req_r),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.link_value, res_r.link_reg, res_r.link_write,
                       res_r.next_pc};
  assign out_tuser  = res_r.not_branch;

endmodule

@@ sim/mips_branch_next_pc_test.sv @@
// ----------------------------------------------------------------------------
// mips_branch_next_pc_test
// Drives resume-address requests through the block and checks every result
// against a local decode of the branch or jump. Directed cases come first,
// then random requests under three idling patterns on both stream sides.
// ----------------------------------------------------------------------------
module mips_branch_next_pc_test;
  import mbnpc_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tuser;

  req_t pending_reqs[$];
  res_t expected_res[$];
  req_t drv_req;
  req_t mon_req;
  res_t mon_exp;
  int   send_idle = 0;
  int   recv_idle = 0;
  int   errors = 0;

  localparam logic [4:0] RegimmCodes[8] = '{RtBltz, RtBgez, RtBltzl, RtBgezl,
                                            RtBltzal, RtBgezal, RtBltzall, RtBgezall};
  localparam logic [5:0] BranchOps[12] = '{OpcSpecial, OpcRegimm, OpcJ, OpcJal,
                                           OpcBeq, OpcBne, OpcBlez, OpcBgtz,
                                           OpcBeql, OpcBnel, OpcBlezl, OpcBgtzl};

  mips_branch_next_pc uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #2 clk = ~clk;

  function automatic res_t resume_of(req_t r);
    logic [5:0]  op;
    logic [4:0]  rtf;
    logic [5:0]  fn;
    logic [63:0] off;
    logic [63:0] cont;
    logic [63:0] btarget;
    logic        neg;
    logic        zero;
    logic        taken;
    logic        link;
    logic        valid;
    res_t        o;
    o = '0;
    o.next_pc = r.pc + 64'd4;
    if (r.in_delay_slot) begin
      op = r.instruction[31:26];
      rtf = r.instruction[20:16];
      fn = r.instruction[5:0];
      cont = r.pc + 64'd8;
      off = {{48{r.instruction[15]}}, r.instruction[15:0]};
      btarget = r.pc + 64'd4 + (off << 2);
      neg = r.rs_value[63];
      zero = (r.rs_value == 64'sd0);
      taken = 1'b0;
      link = 1'b0;
      valid = 1'b1;
      case (op)
        OpcSpecial: begin
          if (fn == FunJr || fn == FunJalr) begin
            o.next_pc = r.rs_value;
            if (fn == FunJalr) begin
              o.link_write = 1'b1;
              o.link_reg = r.instruction[15:11];
              o.link_value = cont;
            end
          end else begin
            valid = 1'b0;
          end
        end
        OpcJ, OpcJal: begin
          o.next_pc = ((r.pc + 64'd4) & 64'hFFFF_FFFF_F000_0000) |
                      {36'd0, r.instruction[25:0], 2'b00};
          if (op == OpcJal) begin
            o.link_write = 1'b1;
            o.link_reg = RaIndex;
            o.link_value = cont;
          end
        end
        OpcRegimm: begin
          case (rtf)
            RtBltzal, RtBltzall: begin link = 1'b1; taken = neg; end
            RtBltz, RtBltzl:     taken = neg;
            RtBgezal, RtBgezall: begin link = 1'b1; taken = !neg; end
            RtBgez, RtBgezl:     taken = !neg;
            default:             valid = 1'b0;
          endcase
          o.next_pc = taken ? btarget : cont;
          if (link) begin
            o.link_write = 1'b1;
            o.link_reg = RaIndex;
            o.link_value = cont;
          end
        end
        OpcBlez, OpcBlezl: o.next_pc = (neg || zero) ? btarget : cont;
        OpcBgtz, OpcBgtzl: o.next_pc = (!neg && !zero) ? btarget : cont;
        OpcBeq, OpcBeql:   o.next_pc = (r.rs_value == r.rt_value) ? btarget : cont;
        OpcBne, OpcBnel:   o.next_pc = (r.rs_value != r.rt_value) ? btarget : cont;
        default:           valid = 1'b0;
      endcase
      if (!valid) begin
        o = '0;
        o.next_pc = cont;
        o.not_branch = 1'b1;
      end
    end
    return o;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_reg();
    case ($urandom_range(0, 6))
      0: return 64'd0;
      1: return 64'h8000_0000_0000_0000;
      2: return 64'h7FFF_FFFF_FFFF_FFFF;
      3: return '1;
      4: return {{56{1'b0}}, 8'($urandom)};
      5: return {{56{1'b1}}, 8'($urandom)};
      default: return rand64();
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.pc = rand64();
    case ($urandom_range(0, 9))
      0: r.pc = {32'hFFFF_FFFF, $urandom};
      1: r.pc = {32'd0, $urandom};
      default: ;
    endcase
    r.in_delay_slot = ($urandom_range(0, 99) < 85);
    r.instruction = $urandom;
    if ($urandom_range(0, 9) < 9)
      r.instruction[31:26] = BranchOps[$urandom_range(0, 11)];
    if (r.instruction[31:26] == OpcRegimm && $urandom_range(0, 9) < 8)
      r.instruction[20:16] = RegimmCodes[$urandom_range(0, 7)];
    if (r.instruction[31:26] == OpcSpecial && $urandom_range(0, 9) < 8)
      r.instruction[5:0] = $urandom_range(0, 1) ? FunJalr : FunJr;
    r.rs_value = rand_reg();
    r.rt_value = ($urandom_range(0, 2) == 0) ? r.rs_value : rand_reg();
    return r;
  endfunction

  task automatic add_req(logic [63:0] pc, logic slot, logic [31:0] insn,
                         logic [63:0] rsv, logic [63:0] rtv);
    req_t r;
    r.pc = pc;
    r.in_delay_slot = slot;
    r.instruction = insn;
    r.rs_value = rsv;
    r.rt_value = rtv;
    pending_reqs.push_back(r);
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // driver and receiver readiness
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          drv_req = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {drv_req.rt_value, drv_req.rs_value, drv_req.instruction, drv_req.pc};
          in_tuser <= drv_req.in_delay_slot;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        mon_req.pc = in_tdata[63:0];
        mon_req.instruction = in_tdata[95:64];
        mon_req.rs_value = in_tdata[159:96];
        mon_req.rt_value = in_tdata[223:160];
        mon_req.in_delay_slot = in_tuser;
        expected_res.push_back(resume_of(mon_req));
      end
      if (out_tvalid && out_tready) begin
        if (expected_res.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          mon_exp = expected_res.pop_front();
          check_field("next_pc", mon_exp.next_pc, out_tdata[63:0]);
          check_field("link_write", 64'(mon_exp.link_write), 64'(out_tdata[64]));
          check_field("link_reg", 64'(mon_exp.link_reg), 64'(out_tdata[69:65]));
          check_field("link_value", mon_exp.link_value, out_tdata[133:70]);
          check_field("not_branch", 64'(mon_exp.not_branch), 64'(out_tuser));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // no delay slot, pc extremes
    add_req(64'd0, 1'b0, $urandom, rand64(), rand64());
    add_req('1, 1'b0, $urandom, rand64(), rand64());
    // jumps, including a region crossing
    add_req(64'h0000_0000_0FFF_FFFC, 1'b1, {OpcJ, 26'h3FF_FFFF}, rand64(), rand64());
    add_req(rand64(), 1'b1, {OpcJal, 26'd0}, rand64(), rand64());
    add_req(rand64(), 1'b1, {OpcSpecial, 5'd3, 15'd0, FunJr}, '1, rand64());
    add_req(rand64(), 1'b1, {OpcSpecial, 5'd3, 5'd0, 5'd0, 5'd0, FunJalr}, rand64(), 64'd0);
    add_req(rand64(), 1'b1, {OpcSpecial, 5'd3, 5'd0, 5'd7, 5'd0, FunJalr}, rand64(), 64'd0);
    // compare branches, wrap of the target at the top of the address space
    add_req('1, 1'b1, {OpcBeq, 10'd0, 16'h7FFF}, 64'd5, 64'd5);
    add_req(rand64(), 1'b1, {OpcBne, 10'd0, 16'h8000}, 64'd5, 64'd6);
    add_req(rand64(), 1'b1, {OpcBeql, 10'd0, 16'h1234}, 64'd1, '1);
    add_req(rand64(), 1'b1, {OpcBnel, 10'd0, 16'hFFFF}, '1, '1);
    add_req(rand64(), 1'b1, {OpcBlez, 10'd0, 16'h0010}, 64'd0, 64'd0);
    add_req(rand64(), 1'b1, {OpcBgtz, 10'd0, 16'h0010}, 64'h8000_0000_0000_0000, 64'd0);
    add_req(rand64(), 1'b1, {OpcBlezl, 10'd0, 16'h0010}, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0);
    add_req(rand64(), 1'b1, {OpcBgtzl, 10'd0, 16'h0010}, 64'd0, 64'd0);
    // every regimm branch, sign of rs alternating
    for (int i = 0; i < 8; i++)
      add_req(rand64(), 1'b1, {OpcRegimm, 5'd2, RegimmCodes[i], 16'hFFF0},
              (i % 2 == 0) ? 64'h8000_0000_0000_0000 : 64'd0, 64'd0);
    // words that are no branch
    add_req(rand64(), 1'b1, {OpcRegimm, 5'd2, 5'h1F, 16'h0040}, '1, 64'd0);
    add_req(rand64(), 1'b1, {OpcSpecial, 20'hFFFFF, 6'h00}, rand64(), 64'd0);
    add_req(rand64(), 1'b1, {6'h3F, 26'h3FF_FFFF}, rand64(), 64'd0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 17 : (phase == 1) ? 65 : 0;
      recv_idle = (phase == 0) ? 65 : (phase == 1) ? 17 : 0;
      for (int n = 0; n < 410; n++)
        pending_reqs.push_back(rand_req());
      while (pending_reqs.size() != 0 || in_tvalid)
        @(posedge clk);
      while (expected_res.size() != 0)
        @(posedge clk);
    end

    repeat (10) @(posedge clk);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
